// ===== rtl/ray_sphere_intersect_assert.svh =====
// ============================================================================
// Ray/sphere intersection assertion macros
// Concurrent assertion shorthands clocked on aclk and disabled in reset.
// ============================================================================
`ifndef RAY_SPHERE_INTERSECT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/rsi_pkg.sv =====
// ============================================================================
// Ray/sphere intersection package
// Number format, internal widths, pipeline stage map and shared types.
// ============================================================================
package rsi_pkg;

    localparam int FRAC_BITS = 16;

    localparam int W_C   = 32;
    localparam int W_A   = W_C + 1;
    localparam int W_D   = 18;
    localparam int W_R   = 31;
    localparam int W_E   = 16;
    localparam int W_P   = W_A + W_D;
    localparam int W_BW  = W_P + 2;
    localparam int W_B   = W_BW - FRAC_BITS;
    localparam int W_M   = W_B;
    localparam int W_LO  = 18;
    localparam int W_HI  = W_M - W_LO;
    localparam int W_ASQ = 2 * W_A;
    localparam int W_AS  = W_ASQ + 2;
    localparam int W_BSQ = 2 * W_M;
    localparam int W_RSQ = 2 * W_R;
    localparam int W_POS = ((W_BSQ > W_AS) ? W_BSQ : W_AS) + 1;
    localparam int W_S   = (W_POS + 1) / 2;
    localparam int W_X   = 2 * W_S;
    localparam int W_REM = W_S + 2;
    localparam int W_T   = ((W_B > W_S + 1) ? W_B : W_S + 1) + 1;
    localparam int W_TD  = W_T + W_D;
    localparam int W_N   = (((W_TD - FRAC_BITS) > W_A) ? (W_TD - FRAC_BITS) : W_A) + 1;

    localparam int IN_W  = 152;
    localparam int OUT_W = 128;

    localparam int S_IN   = 0;
    localparam int S_MUL  = 1;
    localparam int S_SUM  = 2;
    localparam int S_B    = 3;
    localparam int S_PART = 4;
    localparam int S_POS  = 5;
    localparam int S_DISC = 6;
    localparam int S_SQ   = 7;
    localparam int S_ROOT = S_SQ + W_S;
    localparam int S_TD   = S_ROOT + 1;
    localparam int S_OUT  = S_TD + 1;
    localparam int NST    = S_OUT + 1;

    typedef enum logic [2:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_RADIUS   = 3'd3,
        CFG_EPSILON  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0][W_A-1:0]   a;
        logic [2:0][W_D-1:0]   d;
        logic [2:0][W_P-1:0]   p;
        logic [2:0][W_ASQ-1:0] asq;
        logic [W_RSQ-1:0]      rsq;
        logic [W_BW-1:0]       bw;
        logic [W_AS-1:0]       asum;
        logic [W_B-1:0]        b;
        logic [W_M-1:0]        mag;
        logic [2*W_HI-1:0]     phh;
        logic [W_HI+W_LO-1:0]  phl;
        logic [2*W_LO-1:0]     pll;
        logic [W_POS-1:0]      pos;
        logic [W_POS-1:0]      neg;
        logic                  miss;
        logic [W_X-1:0]        x;
        logic [W_REM-1:0]      rem;
        logic [W_S-1:0]        root;
        logic [W_T-1:0]        t;
        logic                  hit;
        logic [2:0][W_TD-1:0]  td;
        logic [W_R-1:0]        distance;
        logic [2:0][W_C-1:0]   n;
    } pl_t;

    typedef struct packed {
        logic                hit;
        logic [W_R-1:0]      distance;
        logic [2:0][W_C-1:0] n;
    } res_t;

endpackage

// ===== rtl/ray_sphere_intersect.sv =====
// ============================================================================
// Ray/sphere intersection
// Tests a stream of rays against one configured sphere in fixed point.
// ============================================================================
// The block takes one ray per clock while s_tready is high and returns one
// result per ray, in order. Most of the pipeline stages belong to the
// square root, which settles one root bit per stage. A two-entry output
// buffer lets the pipeline keep accepting while a result waits.
module ray_sphere_intersect import rsi_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_addr,
    input  logic [31:0]      cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // distance, normal_x, normal_y, normal_z, zero pad
    output logic [OUT_W-1:0] m_tdata,
    // hit
    output logic [0:0]       m_tuser
);

`include "ray_sphere_intersect_assert.svh"

    logic [2:0][W_C-1:0] cen_reg;
    logic [W_R-1:0]      rad_reg;
    logic [W_E-1:0]      eps_reg;

    logic [NST-1:0] v_reg;
    pl_t            pl_reg  [NST];
    pl_t            pl_next [NST];
    pl_t            sq_out  [W_S];
    logic           adv;

    res_t res_in;
    res_t out_reg;
    res_t skid_reg;
    logic out_vld_reg;
    logic skid_vld_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cen_reg <= '0;
            rad_reg <= W_R'(65536);
            eps_reg <= W_E'(66);
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_CENTER_X: cen_reg[0] <= cfg_data;
                CFG_CENTER_Y: cen_reg[1] <= cfg_data;
                CFG_CENTER_Z: cen_reg[2] <= cfg_data;
                CFG_RADIUS:   rad_reg    <= cfg_data[W_R-1:0];
                CFG_EPSILON:  eps_reg    <= cfg_data[W_E-1:0];
                default: ;
            endcase
        end
    end

    genvar gj;
    generate
        for (gj = 0; gj < W_S; gj++) begin : g_sqrt
            rsi_sqrt_step u_step (
                .din  (pl_reg[S_SQ + gj - 1]),
                .dout (sq_out[gj])
            );
        end
    endgenerate

    always_comb begin
        logic signed [W_BW-1:0] sb;
        logic signed [W_T-1:0]  bt, st, et, near, far;
        logic signed [W_N-1:0]  nv;
        logic [W_LO-1:0]        lo;
        logic [W_HI-1:0]        hi;
        logic [W_POS-1:0]       disc;

        pl_next[S_IN] = '0;
        for (int i = 0; i < 3; i++) begin
            pl_next[S_IN].a[i] = W_A'($signed(cen_reg[i]))
                               - W_A'($signed(s_tdata[i*W_C +: W_C]));
            pl_next[S_IN].d[i] = s_tdata[3*W_C + i*W_D +: W_D];
        end

        pl_next[S_MUL] = pl_reg[S_MUL-1];
        for (int i = 0; i < 3; i++) begin
            pl_next[S_MUL].p[i]   = W_P'($signed(pl_reg[S_MUL-1].a[i])
                                       * $signed(pl_reg[S_MUL-1].d[i]));
            pl_next[S_MUL].asq[i] = W_ASQ'($signed(pl_reg[S_MUL-1].a[i])
                                       * $signed(pl_reg[S_MUL-1].a[i]));
        end
        pl_next[S_MUL].rsq = W_RSQ'(rad_reg) * W_RSQ'(rad_reg);

        pl_next[S_SUM] = pl_reg[S_SUM-1];
        pl_next[S_SUM].bw = W_BW'($signed(pl_reg[S_SUM-1].p[0]))
                          + W_BW'($signed(pl_reg[S_SUM-1].p[1]))
                          + W_BW'($signed(pl_reg[S_SUM-1].p[2]));
        pl_next[S_SUM].asum = W_AS'(pl_reg[S_SUM-1].asq[0])
                            + W_AS'(pl_reg[S_SUM-1].asq[1])
                            + W_AS'(pl_reg[S_SUM-1].asq[2]);

        pl_next[S_B] = pl_reg[S_B-1];
        sb = $signed(pl_reg[S_B-1].bw) >>> FRAC_BITS;
        pl_next[S_B].b   = W_B'(sb);
        pl_next[S_B].mag = sb[W_BW-1] ? W_M'(-sb) : W_M'(sb);

        pl_next[S_PART] = pl_reg[S_PART-1];
        lo = pl_reg[S_PART-1].mag[W_LO-1:0];
        hi = pl_reg[S_PART-1].mag[W_M-1:W_LO];
        pl_next[S_PART].phh = (2*W_HI)'(hi) * (2*W_HI)'(hi);
        pl_next[S_PART].phl = (W_HI+W_LO)'(hi) * (W_HI+W_LO)'(lo);
        pl_next[S_PART].pll = (2*W_LO)'(lo) * (2*W_LO)'(lo);

        pl_next[S_POS] = pl_reg[S_POS-1];
        pl_next[S_POS].pos = (W_POS'(pl_reg[S_POS-1].phh) << (2*W_LO))
                           + (W_POS'(pl_reg[S_POS-1].phl) << (W_LO+1))
                           + W_POS'(pl_reg[S_POS-1].pll)
                           + W_POS'(pl_reg[S_POS-1].rsq);
        pl_next[S_POS].neg = W_POS'(pl_reg[S_POS-1].asum);

        pl_next[S_DISC] = pl_reg[S_DISC-1];
        disc = pl_reg[S_DISC-1].pos - pl_reg[S_DISC-1].neg;
        pl_next[S_DISC].miss = pl_reg[S_DISC-1].pos < pl_reg[S_DISC-1].neg;
        pl_next[S_DISC].x    = W_X'(disc);
        pl_next[S_DISC].rem  = '0;
        pl_next[S_DISC].root = '0;

        for (int j = 0; j < W_S; j++) begin
            pl_next[S_SQ + j] = sq_out[j];
        end

        pl_next[S_ROOT] = pl_reg[S_ROOT-1];
        bt   = W_T'($signed(pl_reg[S_ROOT-1].b));
        st   = $signed(W_T'(pl_reg[S_ROOT-1].root));
        et   = $signed(W_T'(eps_reg));
        near = bt - st;
        far  = bt + st;
        if (pl_reg[S_ROOT-1].miss) begin
            pl_next[S_ROOT].hit = 1'b0;
            pl_next[S_ROOT].t   = '0;
        end else if (near > et) begin
            pl_next[S_ROOT].hit = 1'b1;
            pl_next[S_ROOT].t   = near;
        end else if (far > et) begin
            pl_next[S_ROOT].hit = 1'b1;
            pl_next[S_ROOT].t   = far;
        end else begin
            pl_next[S_ROOT].hit = 1'b0;
            pl_next[S_ROOT].t   = '0;
        end

        pl_next[S_TD] = pl_reg[S_TD-1];
        for (int i = 0; i < 3; i++) begin
            pl_next[S_TD].td[i] = W_TD'($signed(pl_reg[S_TD-1].t)
                                      * $signed(pl_reg[S_TD-1].d[i]));
        end
        if (!pl_reg[S_TD-1].hit || pl_reg[S_TD-1].t[W_T-1]) begin
            pl_next[S_TD].distance = '0;
        end else if (|pl_reg[S_TD-1].t[W_T-2:W_R]) begin
            pl_next[S_TD].distance = '1;
        end else begin
            pl_next[S_TD].distance = pl_reg[S_TD-1].t[W_R-1:0];
        end

        pl_next[S_OUT] = pl_reg[S_OUT-1];
        for (int i = 0; i < 3; i++) begin
            nv = W_N'($signed(pl_reg[S_OUT-1].td[i]) >>> FRAC_BITS)
               - W_N'($signed(pl_reg[S_OUT-1].a[i]));
            if (!pl_reg[S_OUT-1].hit) begin
                pl_next[S_OUT].n[i] = '0;
            end else if (nv[W_N-1:W_C-1] == '0 || nv[W_N-1:W_C-1] == '1) begin
                pl_next[S_OUT].n[i] = nv[W_C-1:0];
            end else if (nv[W_N-1]) begin
                pl_next[S_OUT].n[i] = {1'b1, {(W_C-1){1'b0}}};
            end else begin
                pl_next[S_OUT].n[i] = {1'b0, {(W_C-1){1'b1}}};
            end
        end
    end

    assign adv      = !skid_vld_reg;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NST-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pl_reg <= pl_next;
        end
    end

    assign res_in.hit      = pl_reg[S_OUT].hit;
    assign res_in.distance = pl_reg[S_OUT].distance;
    assign res_in.n        = pl_reg[S_OUT].n;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_tready) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (v_reg[S_OUT]) begin
            if (!out_vld_reg || m_tready) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_tready) begin
                out_reg <= skid_reg;
            end
        end else if (v_reg[S_OUT]) begin
            if (!out_vld_reg || m_tready) begin
                out_reg <= res_in;
            end else begin
                skid_reg <= res_in;
            end
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tuser[0] = out_reg.hit;
    assign m_tdata    = {1'b0, out_reg.n[2], out_reg.n[1], out_reg.n[0], out_reg.distance};

    `RSI_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0)
    `RSI_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v_reg[S_IN])
    `RSI_ASSERT_IMP(a_skid_behind_out, skid_vld_reg, out_vld_reg)

endmodule

// ===== rtl/rsi_sqrt_step.sv =====
// ============================================================================
// Square root step
// One restoring digit of the integer square root: two radicand bits in,
// one root bit out.
// ============================================================================
module rsi_sqrt_step import rsi_pkg::*; (
    input  pl_t din,
    output pl_t dout
);

    logic [W_REM-1:0] rem2;
    logic [W_REM-1:0] trial;

    always_comb begin
        dout   = din;
        rem2   = {din.rem[W_REM-3:0], din.x[W_X-1 -: 2]};
        trial  = {din.root, 2'b01};
        dout.x = {din.x[W_X-3:0], 2'b00};
        if (rem2 >= trial) begin
            dout.rem  = rem2 - trial;
            dout.root = {din.root[W_S-2:0], 1'b1};
        end else begin
            dout.rem  = rem2;
            dout.root = {din.root[W_S-2:0], 1'b0};
        end
    end

endmodule

// ===== tb/ray_sphere_intersect_tb.sv =====
// ----------------------------------------------------------------------------
// Ray/sphere intersection testbench
// Streams rays through the intersection block under several sphere settings
// and compares every result with a bit-accurate fixed point predictor. Both
// stream sides idle at random, and one long output stall fills the pipeline.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_tb import rsi_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] org [3];
        logic signed [17:0] dir [3];
    } ray_t;

    typedef struct {
        logic               hit;
        logic [30:0]        distance;
        logic signed [31:0] nrm [3];
    } hit_info_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_addr = '0;
    logic [31:0]       cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic [0:0]        m_tuser;

    logic signed [31:0] sph_center [3];
    logic [30:0]        sph_radius;
    logic [15:0]        sph_eps;

    hit_info_t expected_hits [$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;
    int  hold_pending = 0;
    int  hold_left = 0;
    int  rx_gap = 0;

    ray_sphere_intersect i_dut (.*);

    always #4 aclk = ~aclk;

    function automatic hit_info_t predict_hit(ray_t r);
        logic signed [127:0] a [3];
        logic signed [127:0] d [3];
        logic signed [127:0] bw, b, pos, neg, disc, s, cand, t, n;
        hit_info_t res;
        res.hit = 1'b0;
        res.distance = '0;
        for (int i = 0; i < 3; i++) res.nrm[i] = '0;
        bw = 0;
        neg = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = 128'(sph_center[i]) - 128'(r.org[i]);
            d[i] = 128'(r.dir[i]);
            bw = bw + a[i] * d[i];
            neg = neg + a[i] * a[i];
        end
        b = bw >>> FRAC_BITS;
        pos = b * b + $signed({97'd0, sph_radius}) * $signed({97'd0, sph_radius});
        if (pos < neg) return res;
        disc = pos - neg;
        s = 0;
        for (int bit_i = 47; bit_i >= 0; bit_i--) begin
            cand = s | (128'sd1 <<< bit_i);
            if (cand * cand <= disc) s = cand;
        end
        if (b - s > $signed({112'd0, sph_eps})) t = b - s;
        else if (b + s > $signed({112'd0, sph_eps})) t = b + s;
        else return res;
        res.hit = 1'b1;
        res.distance = (t > 128'sd2147483647) ? 31'h7fffffff : t[30:0];
        for (int i = 0; i < 3; i++) begin
            n = ((t * d[i]) >>> FRAC_BITS) - a[i];
            if (n > 128'sd2147483647) res.nrm[i] = 32'sh7fffffff;
            else if (n < -128'sd2147483648) res.nrm[i] = 32'sh80000000;
            else res.nrm[i] = n[31:0];
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_pending > 0) begin
            hold_left = hold_pending;
            hold_pending = 0;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap = rx_gap - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            rx_gap = $urandom_range(0, 7);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        hit_info_t e;
        logic signed [31:0] got_n [3];
        if (aresetn && m_tvalid && m_tready) begin
            got_n[0] = m_tdata[62:31];
            got_n[1] = m_tdata[94:63];
            got_n[2] = m_tdata[126:95];
            if (expected_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result item %h", m_tdata);
            end else begin
                e = expected_hits.pop_front();
                if (m_tuser[0] !== e.hit || m_tdata[30:0] !== e.distance ||
                    got_n[0] !== e.nrm[0] || got_n[1] !== e.nrm[1] ||
                    got_n[2] !== e.nrm[2]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected hit %0d t %h n %h %h %h, got %0d %h %h %h %h",
                                 e.hit, e.distance, e.nrm[0], e.nrm[1], e.nrm[2], m_tuser[0],
                                 m_tdata[30:0], got_n[0], got_n[1], got_n[2]);
                end
            end
        end
    end

    task automatic send_ray(ray_t r);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, r.dir[2], r.dir[1], r.dir[0], r.org[2], r.org[1], r.org[0]};
        do @(posedge aclk); while (!s_tready);
        expected_hits.push_back(predict_hit(r));
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (NST + 4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_CENTER_X: sph_center[0] = value;
            CFG_CENTER_Y: sph_center[1] = value;
            CFG_CENTER_Z: sph_center[2] = value;
            CFG_RADIUS:   sph_radius = value[30:0];
            CFG_EPSILON:  sph_eps = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] rad, logic [31:0] eps);
        drain_pipeline();
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_EPSILON, eps);
    endtask

    function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        ray_t r;
        r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
        r.dir[0] = 18'(dx); r.dir[1] = 18'(dy); r.dir[2] = 18'(dz);
        return r;
    endfunction

    function automatic ray_t random_ray();
        ray_t r;
        int sel;
        int span;
        sel = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) r.dir[i] = 18'($urandom);
        if (sel < 6) begin
            // Aim roughly at the center from some distance back along the ray.
            for (int i = 0; i < 3; i++)
                r.dir[i] = 18'($signed($urandom_range(0, 131072)) - 65536);
            span = $urandom_range(0, 8 * 65536);
            for (int i = 0; i < 3; i++)
                r.org[i] = 32'(sph_center[i] - ((longint'(span) * r.dir[i]) >>> 16)
                           + $signed($urandom_range(0, 2 * 65536)) - 65536);
        end else if (sel < 8) begin
            for (int i = 0; i < 3; i++) r.org[i] = $urandom;
        end else begin
            for (int i = 0; i < 3; i++)
                r.org[i] = sph_center[i] + $signed($urandom_range(0, 8 * 65536)) - 4 * 65536;
        end
        return r;
    endfunction

    task automatic test_reset_sphere();
        sph_center[0] = 0; sph_center[1] = 0; sph_center[2] = 0;
        sph_radius = 31'(65536);
        sph_eps = 16'(66);
        send_ray(make_ray(0, 0, -2 * 65536, 0, 0, 65536));
        send_ray(make_ray(0, 0, 0, 0, 0, 65536));
        send_ray(make_ray(0, 0, 2 * 65536, 0, 0, 65536));
        send_ray(make_ray(2 * 65536, 0, -2 * 65536, 0, 0, 65536));
        send_ray(make_ray(65536, 0, -2 * 65536, 0, 0, 65536));
        send_ray(make_ray(0, 0, 65536, 0, 0, 65536));
        send_ray(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          -131072, -131072, -131072));
        send_ray(make_ray(32'h80000000, 32'h80000000, 32'h80000000,
                          131071, 131071, 131071));
        send_ray(make_ray(32'h80000000, 0, 0, 65536, 0, 0));
        send_ray(make_ray(0, 32'h7fffffff, 0, 0, -65536, 0));
        send_ray(make_ray(0, 0, 0, 0, 0, 0));
        send_ray(make_ray(0, 0, -3 * 65536, 0, 0, 131071));
    endtask

    task automatic test_extreme_spheres();
        set_sphere(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 16'hffff);
        send_ray(make_ray(32'h80000000, 32'h7fffffff, 0, 65536, -65536, 0));
        send_ray(make_ray(0, 0, 0, 46341, -46341, 0));
        send_ray(make_ray(32'h80000000, 32'h7fffffff, 32'h7fffffff, -131072, 131071, -131072));
        send_ray(make_ray(0, 0, 0, 0, 0, 65536));
        set_sphere(0, 0, 0, 0, 0);
        send_ray(make_ray(0, 0, -65536, 0, 0, 65536));
        send_ray(make_ray(0, 0, 0, 0, 0, 65536));
        drain_pipeline();
        write_reg(cfg_idx_t'(3'd5), 32'hffffffff);
        write_reg(cfg_idx_t'(3'd7), 32'h12345678);
        send_ray(make_ray(0, 0, -65536, 0, 0, 65536));
    endtask

    task automatic test_random_spheres();
        for (int k = 0; k < 8; k++) begin
            if (k % 2 == 0)
                set_sphere($urandom, $urandom, $urandom, $urandom, $urandom);
            else
                set_sphere($signed($urandom_range(0, 64 * 65536)) - 32 * 65536,
                           $signed($urandom_range(0, 64 * 65536)) - 32 * 65536,
                           $signed($urandom_range(0, 64 * 65536)) - 32 * 65536,
                           $urandom_range(0, 4 * 65536), $urandom_range(0, 2000));
            repeat (70) send_ray(random_ray());
        end
    endtask

    task automatic test_output_stall();
        set_sphere(0, 0, 3 * 65536, 2 * 65536, 66);
        hold_pending = 300;
        repeat (100) send_ray(random_ray());
    endtask

    task automatic test_steady_stream();
        set_sphere(65536, -65536, 5 * 65536, 3 * 65536, 100);
        idle_on = 1'b0;
        repeat (80) send_ray(random_ray());
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_sphere();
        test_extreme_spheres();
        test_random_spheres();
        test_output_stall();
        test_steady_stream();
        s_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (NST + 10) @(posedge aclk);
        if (mismatches == 0 && expected_hits.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
